[design/fifo_queue_with_search_assert.svh]
// assertion macros for the queue design files
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// condition holds at every clock edge out of reset
`define FQS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FQS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fqs_pkg.sv]
// types, constants and helper functions of the searchable queue
package fqs_pkg;

   localparam int DEPTH   = 16;
   localparam int WIDTH   = 32;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = PTR_W + 2;
   localparam int COUNT_W = 5;

   localparam logic [1:0] FN_PUSH      = 2'd0;
   localparam logic [1:0] FN_POP_FRONT = 2'd1;
   localparam logic [1:0] FN_POP_REAR  = 2'd2;
   localparam logic [1:0] FN_SEARCH    = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] popped;
      logic               found;
      logic [COUNT_W-1:0] count;
      logic signed [31:0] head_entry;
      logic signed [31:0] tail_entry;
   } rsp_type;

   // sign-extend the 32-bit request value, keep the stored entry width
   function automatic logic [WIDTH-1:0] to_entry(input logic [31:0] v);
      logic [63:0] ext;
      ext = 64'($signed(v));
      return ext[WIDTH-1:0];
   endfunction

   // sign-extend a stored entry and cut it to a 32-bit result field
   function automatic logic [31:0] to_field(input logic [WIDTH-1:0] e);
      logic [63:0] ext;
      ext = 64'($signed(e));
      return ext[31:0];
   endfunction

   // position of the entry ofs places behind the front
   function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
                                             input logic [CNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(ofs);
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

[design/fqs_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
module fqs_ram #(
   parameter int DEPTH_P = 16,
   parameter int WIDTH_P = 32,
   parameter int ADDR_W  = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [WIDTH_P-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [WIDTH_P-1:0] rd_data
);

   logic [WIDTH_P-1:0] mem [DEPTH_P];
   logic [WIDTH_P-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/fifo_queue_with_search.sv]
// Bounded queue of DEPTH entries with push at the rear, pop at either end and
// a search for a value; every request gives exactly one response. Entries sit
// in a single-port-read ram addressed as a ring from a head pointer, while the
// front and rear entries are also held in registers so that pops return at
// once. From acceptance, a push, or any refused or empty-queue request, goes
// straight to the done state; a pop first reads the new front or rear entry
// from the ram, unless the queue becomes empty; a search reads one entry per
// cycle, ending early on the first match. A new request is taken once the
// previous one has reached the response register, even while that response is
// still stalled.
`include "fifo_queue_with_search_assert.svh"

module fifo_queue_with_search
   import fqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FILL = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] head_ptr_ff, head_ptr_in;
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic [WIDTH-1:0] head_val_ff, head_val_in;
   logic [WIDTH-1:0] tail_val_ff, tail_val_in;
   logic [1:0]       func_ff, func_in;
   logic [WIDTH-1:0] key_ff, key_in;
   logic [1:0]       status_ff, status_in;
   logic [31:0]      popped_ff, popped_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [WIDTH-1:0] wr_data;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [WIDTH-1:0] rd_data;

   logic             accept;
   logic [WIDTH-1:0] req_entry;
   logic [CNT_W-1:0] idx_next;

   fqs_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (WIDTH),
      .ADDR_W  (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_entry = to_entry(req_data.value);
   assign idx_next  = idx_ff + CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      head_ptr_in  = head_ptr_ff;
      occ_in       = occ_ff;
      head_val_in  = head_val_ff;
      tail_val_in  = tail_val_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      popped_in    = popped_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = slot(head_ptr_ff, occ_ff);
      wr_data      = req_entry;
      rd_en        = 1'b0;
      rd_addr      = head_ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in   = req_data.func;
               key_in    = req_entry;
               status_in = ST_OK;
               popped_in = '0;
               found_in  = 1'b0;
               idx_in    = '0;
               state_in  = S_DONE;
               case (req_data.func)
                  FN_PUSH: begin
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        occ_in      = occ_ff + CNT_W'(1);
                        tail_val_in = req_entry;
                        if (occ_ff == '0) begin
                           head_val_in = req_entry;
                        end
                     end
                  end
                  FN_POP_FRONT: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        popped_in   = to_field(head_val_ff);
                        head_ptr_in = slot(head_ptr_ff, CNT_W'(1));
                        occ_in      = occ_ff - CNT_W'(1);
                        rd_addr     = slot(head_ptr_ff, CNT_W'(1));
                        // fetch the new front unless the queue drains
                        if (occ_ff != CNT_W'(1)) begin
                           rd_en    = 1'b1;
                           state_in = S_FILL;
                        end
                     end
                  end
                  FN_POP_REAR: begin
                     if (occ_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        popped_in = to_field(tail_val_ff);
                        occ_in    = occ_ff - CNT_W'(1);
                        rd_addr   = slot(head_ptr_ff, occ_ff - CNT_W'(2));
                        if (occ_ff != CNT_W'(1)) begin
                           rd_en    = 1'b1;
                           state_in = S_FILL;
                        end
                     end
                  end
                  default: begin
                     if (occ_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ptr_ff;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_FILL: begin
            if (func_ff == FN_POP_FRONT) begin
               head_val_in = rd_data;
            end else begin
               tail_val_in = rd_data;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // read of the next entry overlaps the compare of this one
            rd_addr = slot(head_ptr_ff, idx_next);
            rd_en   = (idx_next < occ_ff);
            if (rd_data == key_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (idx_next == occ_ff) begin
               state_in = S_DONE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.status     = status_ff;
               rsp_data_in.popped     = popped_ff;
               rsp_data_in.found      = found_ff;
               rsp_data_in.count      = COUNT_W'(occ_ff);
               rsp_data_in.head_entry = (occ_ff == '0) ? '0 : to_field(head_val_ff);
               rsp_data_in.tail_entry = (occ_ff == '0) ? '0 : to_field(tail_val_ff);
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ptr_ff  <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ptr_ff  <= head_ptr_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_val_ff <= head_val_in;
      tail_val_ff <= tail_val_in;
      func_ff     <= func_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      popped_ff   <= popped_in;
      found_ff    <= found_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FQS_ASSERT_ALWAYS(a_occ_bound, occ_ff <= CNT_W'(DEPTH), "occupancy above capacity")
   `FQS_ASSERT_NEXT(a_accept_busy, accept, state_ff != S_IDLE, "request taken but no work started")
   `FQS_ASSERT_IMPL(a_full_count, rsp_valid_ff && rsp_data_ff.status == ST_FULL, rsp_data_ff.count == COUNT_W'(DEPTH), "full status with spare room")
   `FQS_ASSERT_IMPL(a_empty_resp, rsp_valid_ff && rsp_data_ff.status == ST_EMPTY, rsp_data_ff.count == '0 && rsp_data_ff.popped == '0, "empty status on a non-empty queue")

endmodule

[verif/tb_top.sv]
// self-checking testbench for the searchable queue, with its own model of the queue
module tb_top
   import fqs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 24;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   fifo_queue_with_search dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the queue contents
   logic [WIDTH-1:0] held [DEPTH];
   int unsigned      front_idx = 0;
   int unsigned      held_count = 0;
   rsp_type          queue_outcomes [$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_left = 0;

   function automatic logic [31:0] as_field(input logic [WIDTH-1:0] e);
      logic signed [63:0] ext;
      ext = 64'($signed(e));
      return ext[31:0];
   endfunction

   function automatic logic [WIDTH-1:0] rear_entry();
      return held[(front_idx + held_count - 1) % DEPTH];
   endfunction

   task automatic apply_queue_op(input req_type r);
      rsp_type          o;
      logic signed [63:0] ext;
      logic [WIDTH-1:0] entry;
      ext = 64'(r.value);
      entry = ext[WIDTH-1:0];
      o = '0;
      o.status = ST_OK;
      case (r.func)
         FN_PUSH: begin
            if (held_count == DEPTH) begin
               o.status = ST_FULL;
            end else begin
               held[(front_idx + held_count) % DEPTH] = entry;
               held_count++;
            end
         end
         FN_POP_FRONT: begin
            if (held_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.popped = as_field(held[front_idx]);
               front_idx = (front_idx + 1) % DEPTH;
               held_count--;
            end
         end
         FN_POP_REAR: begin
            if (held_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.popped = as_field(rear_entry());
               held_count--;
            end
         end
         default: begin
            for (int i = 0; i < held_count; i++) begin
               if (held[(front_idx + i) % DEPTH] == entry) begin
                  o.found = 1'b1;
               end
            end
         end
      endcase
      o.count = COUNT_W'(held_count);
      if (held_count != 0) begin
         o.head_entry = as_field(held[front_idx]);
         o.tail_entry = as_field(rear_entry());
      end
      queue_outcomes.push_back(o);
   endtask

   task automatic send_request(input logic [1:0] fn, input logic [31:0] val);
      req_type r;
      r.func = fn;
      r.value = val;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      apply_queue_op(r);
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (queue_outcomes.size() != 0);
   endtask

   function automatic logic [31:0] entry_value();
      case ($urandom_range(3))
         0: return 32'($signed($urandom_range(15)) - 8);
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // when entries are held, half the searches look for one of them
   function automatic logic [31:0] search_value();
      if (held_count != 0 && $urandom_range(1)) begin
         return as_field(held[(front_idx + $urandom_range(held_count - 1)) % DEPTH]);
      end
      return entry_value();
   endfunction

   task automatic test_empty_queue();
      send_request(FN_POP_FRONT, 32'hffff_ffff);
      send_request(FN_POP_REAR, 32'h0);
      send_request(FN_SEARCH, 32'h0);
   endtask

   task automatic test_extreme_values();
      send_request(FN_PUSH, 32'h8000_0000);
      send_request(FN_PUSH, 32'h7fff_ffff);
      send_request(FN_PUSH, 32'h0);
      send_request(FN_PUSH, 32'hffff_ffff);
      send_request(FN_PUSH, 32'h5555_5555);
      send_request(FN_PUSH, 32'haaaa_aaaa);
      send_request(FN_SEARCH, 32'hffff_ffff);
      send_request(FN_SEARCH, 32'h8000_0000);
      send_request(FN_SEARCH, 32'h1234_5678);
      send_request(FN_POP_FRONT, 32'h0);
      send_request(FN_POP_REAR, 32'h0);
   endtask

   task automatic test_fill_to_full();
      while (held_count < DEPTH) begin
         send_request(FN_PUSH, $urandom);
      end
      send_request(FN_PUSH, 32'h0bad_0bad);
      // rear entry is the deepest a search can go
      send_request(FN_SEARCH, as_field(rear_entry()));
      send_request(FN_POP_FRONT, 32'h0);
      wait_all_responses();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_left = 80;
      for (int k = 0; k < 12; k++) begin
         send_request((k % 2) ? FN_POP_FRONT : FN_PUSH, $urandom);
      end
      wait_all_responses();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
      int         push_pct;
      int         pick;
      logic [1:0] fn;
      logic [31:0] val;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      push_pct = 65;
      for (int k = 0; k < n; k++) begin
         // switch at random between filling and draining bursts so both ends get exercised
         if (k % 48 == 0) begin
            push_pct = $urandom_range(1) ? 65 : 20;
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            fn = FN_SEARCH;
            val = search_value();
         end else if (pick < 15 + push_pct) begin
            fn = FN_PUSH;
            val = entry_value();
         end else begin
            fn = $urandom_range(1) ? FN_POP_FRONT : FN_POP_REAR;
            val = $urandom;
         end
         send_request(fn, val);
      end
      wait_all_responses();
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (queue_outcomes.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none actual %h",
                     $time, rsp_data);
            error_count++;
         end else begin
            want = queue_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("popped", want.popped, rsp_data.popped);
            check_field("found", 32'(want.found), 32'(rsp_data.found));
            check_field("count", 32'(want.count), 32'(rsp_data.count));
            check_field("head_entry", want.head_entry, rsp_data.head_entry);
            check_field("tail_entry", want.tail_entry, rsp_data.tail_entry);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_queue();
      test_extreme_values();
      test_fill_to_full();
      test_backpressure();
      test_random_traffic(0, 0, 130);
      test_random_traffic(49, 0, 130);
      test_random_traffic(0, 49, 130);
      test_random_traffic(20, 20, 130);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && queue_outcomes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
